FILE: rtl/core/brmc_pkg.sv
// Shared widths, codes, types and constants of the balance robot motor controller.
`default_nettype none

package brmc_pkg;

  // Port and register widths
  localparam int GAIN_W     = 24;
  localparam int PT_W       = 16;
  localparam int DZ_W       = 10;
  localparam int IN_W       = 16;
  localparam int LINE_W     = 8;
  localparam int DUTY_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Serial multiply-accumulate: multiplicands are gains, multipliers go LSB first
  localparam int MC_W      = GAIN_W;
  localparam int MP_W      = 26;
  localparam int HI_W      = MC_W + 3;
  localparam int P_W       = 51;
  localparam int MAC_CNT_W = $clog2(MP_W);

  // Fraction bits: gain Q.8 times a Q.8 signal gives Q.16
  localparam int FRAC_W  = 8;
  localparam int FRAC2_W = 16;

  // Controller constants
  localparam int DRIVE_LIMIT    = 5800;
  localparam int INTEGRAL_LIMIT = 10000;
  localparam int FALL_ANGLE     = 80 * 256;
  localparam int DUTY_MAX       = 8191;
  localparam int LINE_CENTER    = 64;
  localparam int DUTY_MUL       = 117;
  localparam int DUTY_DIV       = 100;
  localparam int FILT_DIV       = 5;

  // Register reset values
  localparam logic [GAIN_W-1:0] BAL_KP_RST = 24'd51200;
  localparam logic [GAIN_W-1:0] BAL_KD_RST = 24'd256;
  localparam logic [GAIN_W-1:0] SPD_KP_RST = 24'hFFCC00;
  localparam logic [GAIN_W-1:0] SPD_KI_RST = 24'hFFFFBD;
  localparam logic [GAIN_W-1:0] STR_KP_RST = 24'd4608;
  localparam logic [GAIN_W-1:0] STR_KD_RST = 24'd46;
  localparam logic [PT_W-1:0]   BAL_PT_RST = 16'd0;
  localparam logic [DZ_W-1:0]   DZ_RST     = 10'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAL_KP,
    REG_BAL_KD,
    REG_SPD_KP,
    REG_SPD_KI,
    REG_STR_KP,
    REG_STR_KD,
    REG_BAL_PT,
    REG_DEAD_ZONE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FILT,
    ST_INTEG,
    ST_SPD_GO,
    ST_SPD,
    ST_TRN_GO,
    ST_TRN,
    ST_MIX,
    ST_DL_GO,
    ST_DL,
    ST_DR_GO,
    ST_DR,
    ST_DONE
  } state_t;

  // Operands of one pass: a*b + c*d
  typedef struct packed {
    logic signed [MC_W-1:0] a;
    logic signed [MP_W-1:0] b;
    logic signed [MC_W-1:0] c;
    logic signed [MP_W-1:0] d;
  } mac_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/brmc_smac.sv
// Bit-serial signed multiply-accumulate unit computing a*b + c*d.
`default_nettype none

module brmc_smac import brmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mac_op_t               op,
  output logic                  busy,
  output logic signed [P_W-1:0] prod
);

  logic signed [MC_W-1:0]    ma;
  logic signed [MC_W-1:0]    mc;
  logic [MP_W-1:0]           mb;
  logic [MP_W-1:0]           md;
  logic signed [HI_W-1:0]    hi;
  logic [MP_W-1:0]           lo;
  logic [MAC_CNT_W-1:0]      cnt;
  logic                      last;
  logic signed [HI_W-1:0]    pa;
  logic signed [HI_W-1:0]    pc;
  logic signed [HI_W-1:0]    t;
  logic [HI_W+MP_W-1:0]      full;

  // sign bit of the multiplier weighs negative
  assign last = (cnt == MAC_CNT_W'(MP_W - 1));
  assign pa   = mb[0] ? {{(HI_W-MC_W){ma[MC_W-1]}}, ma} : '0;
  assign pc   = md[0] ? {{(HI_W-MC_W){mc[MC_W-1]}}, mc} : '0;
  assign t    = last ? (hi - pa - pc) : (hi + pa + pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma <= op.a;
      mb <= op.b;
      mc <= op.c;
      md <= op.d;
      hi <= '0;
    end else if (busy) begin
      hi <= t >>> 1;
      lo <= {t[0], lo[MP_W-1:1]};
      mb <= mb >> 1;
      md <= md >> 1;
    end
  end

  assign full = {hi, lo};
  assign prod = full[P_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/balance_robot_motor_controller_unit.sv
// Top level of the two-wheel self-balancing cascade motor controller.
// One input beat is one control tick: tilt angle and rate, both encoder counts,
// movement target, line position and yaw rate. One output beat follows with a
// PWM duty and direction bit for each motor plus the fallen flag. From input
// beat to output beat a tick runs the filter divide by 5 (with the balance
// multiply run beside it), the speed and turn multiply-accumulate passes (one
// multiplier bit per cycle for 26 bits) and two duty divides by 100 (one
// quotient bit per cycle for 27 bits), joined by sequencer steps. in_ready is
// high only between ticks; a finished result waits in the output register while
// the next tick is taken in. Gains are signed Q16.8; terms truncate toward zero.
// The user must write registers through cfg_wen/cfg_idx/cfg_data between ticks
// only; the block itself does not enforce this.
`default_nettype none

module balance_robot_motor_controller_unit import brmc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] tilt_angle,
  input  logic signed [IN_W-1:0] tilt_rate,
  input  logic signed [IN_W-1:0] left_count,
  input  logic signed [IN_W-1:0] right_count,
  input  logic signed [IN_W-1:0] move_target,
  input  logic [LINE_W-1:0]      line_pos,
  input  logic signed [IN_W-1:0] yaw_rate,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DUTY_W-1:0]      left_duty,
  output logic [DUTY_W-1:0]      right_duty,
  output logic                   left_fwd,
  output logic                   right_fwd,
  output logic                   fallen
);

  // Internal widths
  localparam int FS_W      = MP_W;          // filtered speed, |x| <= 2^24
  localparam int DI_W      = MP_W;          // displacement integral
  localparam int IS_W      = DI_W + 1;      // integral before clamp
  localparam int FN_W      = FS_W + 2;      // filter numerator
  localparam int DV_W      = FN_W - 1;      // divider dividend (magnitude)
  localparam int DD_W      = 7;             // divisor / remainder
  localparam int DV_CNT_W  = $clog2(DV_W);
  localparam int T_W       = P_W - FRAC_W;  // one term after scaling
  localparam int MIX_W     = T_W + 2;
  localparam int DRV_W     = 14;            // clamped drive, signed
  localparam int DM_W      = 20;            // |drive| * 117
  localparam int DS_W      = DUTY_W + 1;
  localparam int ERR_W     = IN_W + 1;

  localparam logic signed [IN_W-1:0]  FALL_LIM = IN_W'(FALL_ANGLE);
  localparam logic signed [IS_W-1:0]  ILIM     = IS_W'(INTEGRAL_LIMIT * 256);
  localparam logic signed [IS_W-1:0]  ILIM_NEG = -ILIM;
  localparam logic signed [MIX_W-1:0] DLIM     = MIX_W'(DRIVE_LIMIT);
  localparam logic signed [MIX_W-1:0] DLIM_NEG = -DLIM;

  // Configuration registers
  logic signed [GAIN_W-1:0] bal_kp, bal_kd, spd_kp, spd_ki, str_kp, str_kd;
  logic signed [PT_W-1:0]   bal_pt;
  logic [DZ_W-1:0]          dead_zone;

  // Captured tick inputs
  logic signed [IN_W-1:0]   ang, rate, lcnt, rcnt, tgt, yaw;
  logic [LINE_W-1:0]        line;

  // Controller state
  logic signed [FS_W-1:0]   fs;
  logic signed [DI_W-1:0]   di;

  state_t state, state_next;

  logic                     mac_start, mac_busy;
  mac_op_t                  mac_op;
  logic signed [P_W-1:0]    mac_prod;

  logic                     dv_start, dv_busy;
  logic [DV_W-1:0]          dv_num, dv_in;
  logic [DD_W-1:0]          dv_rem, dv_div, dv_dsr, dv_rem_next;
  logic [DD_W:0]            dv_trial, dv_diff;
  logic                     dv_ge;
  logic [DV_CNT_W-1:0]      dv_cnt;

  logic                     is_fallen;
  logic signed [ERR_W-1:0]  bal_err, yaw_neg;
  logic signed [LINE_W:0]   line_off;
  logic signed [ERR_W-1:0]  cnt_sum;
  logic signed [FN_W-1:0]   fnum, fnum_abs;
  logic                     fneg;
  logic signed [FS_W-1:0]   fq, filt_val;
  logic                     filt_done;
  logic signed [IS_W-1:0]   isum, isum_c;
  logic signed [DI_W-1:0]   integ;

  logic signed [P_W-1:0]    sh16, sh8;
  logic                     inc16, inc8;
  logic signed [T_W-1:0]    q16, q8, turn;
  logic signed [MIX_W-1:0]  base, q16_ext, turn_ext;
  logic signed [DRV_W-1:0]  lm, rm, dsel, dabs;
  logic [DUTY_W-1:0]        dmag;
  logic [DM_W-1:0]          dmul;
  logic [DS_W-1:0]          duty_sum;
  logic [DUTY_W-1:0]        duty_sat, ld, rd;

  function automatic logic signed [DRV_W-1:0] drive_clamp(input logic signed [MIX_W-1:0] x);
    logic signed [MIX_W-1:0] c;
    begin
      if (x > DLIM) begin
        c = DLIM;
      end else if (x < DLIM_NEG) begin
        c = DLIM_NEG;
      end else begin
        c = x;
      end
      return c[DRV_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      bal_kp    <= BAL_KP_RST;
      bal_kd    <= BAL_KD_RST;
      spd_kp    <= SPD_KP_RST;
      spd_ki    <= SPD_KI_RST;
      str_kp    <= STR_KP_RST;
      str_kd    <= STR_KD_RST;
      bal_pt    <= BAL_PT_RST;
      dead_zone <= DZ_RST;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_BAL_KP:    bal_kp    <= cfg_data[GAIN_W-1:0];
        REG_BAL_KD:    bal_kd    <= cfg_data[GAIN_W-1:0];
        REG_SPD_KP:    spd_kp    <= cfg_data[GAIN_W-1:0];
        REG_SPD_KI:    spd_ki    <= cfg_data[GAIN_W-1:0];
        REG_STR_KP:    str_kp    <= cfg_data[GAIN_W-1:0];
        REG_STR_KD:    str_kd    <= cfg_data[GAIN_W-1:0];
        REG_BAL_PT:    bal_pt    <= cfg_data[PT_W-1:0];
        REG_DEAD_ZONE: dead_zone <= cfg_data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ang  <= tilt_angle;
      rate <= tilt_rate;
      lcnt <= left_count;
      rcnt <= right_count;
      tgt  <= move_target;
      line <= line_pos;
      yaw  <= yaw_rate;
    end
  end

  assign is_fallen = (ang > FALL_LIM) || (ang < -FALL_LIM);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign filt_done = !dv_busy && !mac_busy;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mac_start  = 1'b0;
    dv_start   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // balance multiply runs beside the filter divide
        mac_start  = 1'b1;
        dv_start   = 1'b1;
        state_next = ST_FILT;
      end
      ST_FILT: begin
        if (filt_done) begin
          state_next = ST_INTEG;
        end
      end
      ST_INTEG:  state_next = ST_SPD_GO;
      ST_SPD_GO: begin
        mac_start  = 1'b1;
        state_next = ST_SPD;
      end
      ST_SPD: begin
        if (!mac_busy) begin
          state_next = ST_TRN_GO;
        end
      end
      ST_TRN_GO: begin
        mac_start  = 1'b1;
        state_next = ST_TRN;
      end
      ST_TRN: begin
        if (!mac_busy) begin
          state_next = ST_MIX;
        end
      end
      ST_MIX:    state_next = ST_DL_GO;
      ST_DL_GO: begin
        dv_start   = 1'b1;
        state_next = ST_DL;
      end
      ST_DL: begin
        if (!dv_busy) begin
          state_next = ST_DR_GO;
        end
      end
      ST_DR_GO: begin
        dv_start   = 1'b1;
        state_next = ST_DR;
      end
      ST_DR: begin
        if (!dv_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- MAC operands
  assign bal_err  = {ang[IN_W-1], ang} - {bal_pt[PT_W-1], bal_pt};
  assign line_off = (LINE_W + 1)'(LINE_CENTER) - {1'b0, line};
  assign yaw_neg  = -{yaw[IN_W-1], yaw};

  always_comb begin
    case (state)
      ST_SPD_GO: begin
        mac_op.a = spd_kp;
        mac_op.b = fs;
        mac_op.c = spd_ki;
        mac_op.d = integ;
      end
      ST_TRN_GO: begin
        // turn = -(line - 64)*kp - yaw*kd
        mac_op.a = str_kp;
        mac_op.b = {{(MP_W-LINE_W-1){line_off[LINE_W]}}, line_off};
        mac_op.c = str_kd;
        mac_op.d = {{(MP_W-ERR_W){yaw_neg[ERR_W-1]}}, yaw_neg};
      end
      default: begin
        mac_op.a = bal_kp;
        mac_op.b = {{(MP_W-ERR_W){bal_err[ERR_W-1]}}, bal_err};
        mac_op.c = bal_kd;
        mac_op.d = {{(MP_W-IN_W){rate[IN_W-1]}}, rate};
      end
    endcase
  end

  brmc_smac u_smac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .op    (mac_op),
    .busy  (mac_busy),
    .prod  (mac_prod)
  );

  // truncate toward zero: floor, plus one when negative with bits dropped
  assign sh16  = mac_prod >>> FRAC2_W;
  assign sh8   = mac_prod >>> FRAC_W;
  assign inc16 = mac_prod[P_W-1] & (|mac_prod[FRAC2_W-1:0]);
  assign inc8  = mac_prod[P_W-1] & (|mac_prod[FRAC_W-1:0]);
  assign q16   = sh16[T_W-1:0] + T_W'(inc16);
  assign q8    = sh8[T_W-1:0] + T_W'(inc8);

  // ---------------------------------------------------------------- divider
  // filter: (4*fs + 256*(left+right)) / 5, on the magnitude
  assign cnt_sum  = {lcnt[IN_W-1], lcnt} + {rcnt[IN_W-1], rcnt};
  assign fnum     = {fs, 2'b00} + {{(FN_W-ERR_W-8){cnt_sum[ERR_W-1]}}, cnt_sum, 8'd0};
  assign fnum_abs = fnum[FN_W-1] ? -fnum : fnum;

  // duty: |drive| * 117 / 100
  assign dsel = (state == ST_DR_GO) ? rm : lm;
  assign dabs = dsel[DRV_W-1] ? -dsel : dsel;
  assign dmag = dabs[DUTY_W-1:0];
  assign dmul = DM_W'(dmag) * DM_W'(DUTY_MUL);

  always_comb begin
    if (state == ST_LOAD) begin
      dv_in  = fnum_abs[DV_W-1:0];
      dv_dsr = DD_W'(FILT_DIV);
    end else begin
      dv_in  = {{(DV_W-DM_W){1'b0}}, dmul};
      dv_dsr = DD_W'(DUTY_DIV);
    end
  end

  // restoring division, one quotient bit a cycle
  assign dv_trial    = {dv_rem, dv_num[DV_W-1]};
  assign dv_diff     = dv_trial - {1'b0, dv_div};
  assign dv_ge       = (dv_trial >= {1'b0, dv_div});
  assign dv_rem_next = dv_ge ? dv_diff[DD_W-1:0] : dv_trial[DD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_cnt  <= '0;
    end else if (dv_start) begin
      dv_busy <= 1'b1;
      dv_cnt  <= '0;
    end else if (dv_busy) begin
      dv_cnt <= dv_cnt + 1'b1;
      if (dv_cnt == DV_CNT_W'(DV_W - 1)) begin
        dv_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_num <= dv_in;
      dv_rem <= '0;
      dv_div <= dv_dsr;
    end else if (dv_busy) begin
      dv_num <= {dv_num[DV_W-2:0], dv_ge};
      dv_rem <= dv_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      fneg <= fnum[FN_W-1];
    end
  end

  assign fq       = {1'b0, dv_num[FS_W-2:0]};
  assign filt_val = fneg ? -fq : fq;

  // ---------------------------------------------------------------- speed state
  assign isum = {di[DI_W-1], di} + {fs[FS_W-1], fs} - {{(IS_W-IN_W){tgt[IN_W-1]}}, tgt};

  always_comb begin
    if (isum > ILIM) begin
      isum_c = ILIM;
    end else if (isum < ILIM_NEG) begin
      isum_c = ILIM_NEG;
    end else begin
      isum_c = isum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs <= '0;
      di <= '0;
    end else begin
      if (state == ST_FILT && filt_done) begin
        fs <= filt_val;
      end
      // fallen robot drops the integral after this tick's speed term uses it
      if (state == ST_INTEG) begin
        di <= is_fallen ? '0 : isum_c[DI_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- terms and mix
  assign q16_ext  = {{(MIX_W-T_W){q16[T_W-1]}}, q16};
  assign turn_ext = {{(MIX_W-T_W){turn[T_W-1]}}, turn};

  always_ff @(posedge clk) begin
    case (state)
      ST_INTEG: begin
        integ <= isum_c[DI_W-1:0];
        base  <= q16_ext;                 // balance term
      end
      ST_SPD: begin
        if (!mac_busy) begin
          base <= base + q16_ext;         // plus speed term
        end
      end
      ST_TRN: begin
        if (!mac_busy) begin
          turn <= q8;
        end
      end
      ST_MIX: begin
        lm <= drive_clamp(base + turn_ext);
        rm <= drive_clamp(base - turn_ext);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- duty
  assign duty_sum = DS_W'(dead_zone) + dv_num[DS_W-1:0];
  assign duty_sat = (duty_sum > DS_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : duty_sum[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (state == ST_DL && !dv_busy) begin
      ld <= duty_sat;
    end
    if (state == ST_DR && !dv_busy) begin
      rd <= duty_sat;
    end
  end

  // ---------------------------------------------------------------- output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      left_duty  <= ld;
      right_duty <= rd;
      left_fwd   <= (lm > 0);
      right_fwd  <= !(rm > 0);
      fallen     <= is_fallen;
    end
  end

endmodule

`default_nettype wire

FILE: test/brmc_checker.sv
`timescale 1ns / 100ps
// Scoreboard: predicts each tick's motor command and checks the output beats against it.
module brmc_checker import brmc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic signed [IN_W-1:0] tilt_angle,
  input  logic signed [IN_W-1:0] tilt_rate,
  input  logic signed [IN_W-1:0] left_count,
  input  logic signed [IN_W-1:0] right_count,
  input  logic signed [IN_W-1:0] move_target,
  input  logic [LINE_W-1:0]      line_pos,
  input  logic signed [IN_W-1:0] yaw_rate,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [DUTY_W-1:0]      left_duty,
  input  logic [DUTY_W-1:0]      right_duty,
  input  logic                   left_fwd,
  input  logic                   right_fwd,
  input  logic                   fallen,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              left_fwd;
    logic              right_fwd;
    logic              fallen;
  } motor_cmd_t;

  logic [CFG_DATA_W-1:0] ctrl_regs [8];
  longint                filt_speed;
  longint                disp_integ;
  motor_cmd_t            pending_cmds [$];
  int                    n_fail;
  int                    n_shown;

  initial begin
    n_fail  = 0;
    n_shown = 0;
  end

  function automatic longint clamp_to(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_for(longint drive, longint dz);
    longint mag;
    longint d;
    mag = (drive < 0) ? -drive : drive;
    d = dz + (mag * DUTY_MUL) / DUTY_DIV;
    if (d > DUTY_MAX) d = DUTY_MAX;
    return d[DUTY_W-1:0];
  endfunction

  // One control tick; advances the speed filter and displacement integral.
  function automatic motor_cmd_t motor_command_for(
    input logic signed [IN_W-1:0] angle_in,
    input logic signed [IN_W-1:0] rate_in,
    input logic signed [IN_W-1:0] lcnt_in,
    input logic signed [IN_W-1:0] rcnt_in,
    input logic signed [IN_W-1:0] target_in,
    input logic [LINE_W-1:0]      line_in,
    input logic signed [IN_W-1:0] yaw_in
  );
    longint ang, rate, lcnt, rcnt, tgt, line, yaw;
    longint bkp, bkd, skp, ski, tkp, tkd, pt, dz;
    longint bal, filt, integ, spd, trn, left, right;
    logic   down;
    motor_cmd_t cmd;
    ang  = angle_in;
    rate = rate_in;
    lcnt = lcnt_in;
    rcnt = rcnt_in;
    tgt  = target_in;
    line = line_in;
    yaw  = yaw_in;
    bkp  = $signed(ctrl_regs[REG_BAL_KP]);
    bkd  = $signed(ctrl_regs[REG_BAL_KD]);
    skp  = $signed(ctrl_regs[REG_SPD_KP]);
    ski  = $signed(ctrl_regs[REG_SPD_KI]);
    tkp  = $signed(ctrl_regs[REG_STR_KP]);
    tkd  = $signed(ctrl_regs[REG_STR_KD]);
    pt   = $signed(ctrl_regs[REG_BAL_PT][PT_W-1:0]);
    dz   = ctrl_regs[REG_DEAD_ZONE][DZ_W-1:0];

    down = (ang > FALL_ANGLE) || (ang < -FALL_ANGLE);
    bal  = (bkp * (ang - pt) + bkd * rate) / 65536;

    filt  = (4 * filt_speed + 256 * (lcnt + rcnt)) / FILT_DIV;
    integ = clamp_to(disp_integ + filt - tgt, INTEGRAL_LIMIT * 256);
    spd   = (skp * filt + ski * integ) / 65536;
    // integral is dropped only after this tick's speed term used it
    if (down) integ = 0;
    filt_speed = filt;
    disp_integ = integ;

    trn = (-(line - LINE_CENTER) * tkp * 256 - yaw * tkd * 256) / 65536;

    left  = clamp_to(bal + spd + trn, DRIVE_LIMIT);
    right = clamp_to(bal + spd - trn, DRIVE_LIMIT);

    cmd.left_duty  = duty_for(left, dz);
    cmd.right_duty = duty_for(right, dz);
    cmd.left_fwd   = left > 0;
    cmd.right_fwd  = !(right > 0);
    cmd.fallen     = down;
    return cmd;
  endfunction

  always @(posedge clk) begin
    motor_cmd_t got;
    motor_cmd_t want;
    if (rst) begin
      ctrl_regs[REG_BAL_KP]    = BAL_KP_RST;
      ctrl_regs[REG_BAL_KD]    = BAL_KD_RST;
      ctrl_regs[REG_SPD_KP]    = SPD_KP_RST;
      ctrl_regs[REG_SPD_KI]    = SPD_KI_RST;
      ctrl_regs[REG_STR_KP]    = STR_KP_RST;
      ctrl_regs[REG_STR_KD]    = STR_KD_RST;
      ctrl_regs[REG_BAL_PT]    = CFG_DATA_W'(BAL_PT_RST);
      ctrl_regs[REG_DEAD_ZONE] = CFG_DATA_W'(DZ_RST);
      filt_speed = 0;
      disp_integ = 0;
      pending_cmds.delete();
    end else begin
      if (cfg_wen) ctrl_regs[cfg_idx] = cfg_data;
      if (out_valid && out_ready) begin
        got = '{left_duty, right_duty, left_fwd, right_fwd, fallen};
        if (pending_cmds.size() == 0) begin
          n_fail++;
          if (n_shown < 10) begin
            n_shown++;
            $display("[%0t] unexpected output beat: duty L%0d R%0d fwd %b%b fallen %b",
                     $time, got.left_duty, got.right_duty, got.left_fwd, got.right_fwd,
                     got.fallen);
          end
        end else begin
          want = pending_cmds.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_shown < 10) begin
              n_shown++;
              $display("[%0t] command mismatch: exp duty L%0d R%0d fwd %b%b fallen %b",
                       $time, want.left_duty, want.right_duty, want.left_fwd,
                       want.right_fwd, want.fallen);
              $display("                        got duty L%0d R%0d fwd %b%b fallen %b",
                       got.left_duty, got.right_duty, got.left_fwd, got.right_fwd,
                       got.fallen);
            end
          end
        end
      end
      if (in_valid && in_ready)
        pending_cmds.push_back(motor_command_for(tilt_angle, tilt_rate, left_count,
                                                 right_count, move_target, line_pos,
                                                 yaw_rate));
    end
    fail_count <= n_fail;
    pending    <= pending_cmds.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Top of the motor controller regression: clock, reset, tick stimulus, gain programming, verdict.
module tb;
  import brmc_pkg::*;

  localparam int MAX_GAP      = 10;
  localparam int HOLD_CYCLES  = 800;     // long output back-pressure stretch
  localparam int DRAIN_CYCLES = 200;     // wait after the last result for stray beats
  localparam int CYCLE_LIMIT  = 500000;  // watchdog limit for ~470 ticks, worst case

  // One control tick as the sender sees it
  typedef struct packed {
    logic signed [IN_W-1:0] angle;
    logic signed [IN_W-1:0] rate;
    logic signed [IN_W-1:0] lcnt;
    logic signed [IN_W-1:0] rcnt;
    logic signed [IN_W-1:0] target;
    logic [LINE_W-1:0]      line;
    logic signed [IN_W-1:0] yaw;
  } tick_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [IN_W-1:0] tilt_angle;
  logic signed [IN_W-1:0] tilt_rate;
  logic signed [IN_W-1:0] left_count;
  logic signed [IN_W-1:0] right_count;
  logic signed [IN_W-1:0] move_target;
  logic [LINE_W-1:0]      line_pos;
  logic signed [IN_W-1:0] yaw_rate;
  logic                   out_valid;
  logic                   out_ready;
  logic [DUTY_W-1:0]      left_duty;
  logic [DUTY_W-1:0]      right_duty;
  logic                   left_fwd;
  logic                   right_fwd;
  logic                   fallen;

  logic rx_ready;   // receiver's own per-beat willingness
  logic hold_off;   // long back-pressure window, overrides rx_ready
  logic hold_go;
  logic tx_idle;    // sender inserts random gaps
  logic rx_idle;    // receiver inserts random stalls
  int   fail_count;
  int   pending;
  int   cycle_cnt;
  int   cruise;     // slowly drifting wheel speed for realistic encoder sequences

  assign out_ready = rx_ready && !hold_off;

  balance_robot_motor_controller_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .tilt_angle (tilt_angle),
    .tilt_rate  (tilt_rate),
    .left_count (left_count),
    .right_count(right_count),
    .move_target(move_target),
    .line_pos   (line_pos),
    .yaw_rate   (yaw_rate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_duty  (left_duty),
    .right_duty (right_duty),
    .left_fwd   (left_fwd),
    .right_fwd  (right_fwd),
    .fallen     (fallen)
  );

  brmc_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .tilt_angle (tilt_angle),
    .tilt_rate  (tilt_rate),
    .left_count (left_count),
    .right_count(right_count),
    .move_target(move_target),
    .line_pos   (line_pos),
    .yaw_rate   (yaw_rate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_duty  (left_duty),
    .right_duty (right_duty),
    .left_fwd   (left_fwd),
    .right_fwd  (right_fwd),
    .fallen     (fallen),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("balance_robot_motor_controller_unit regression: fail");
      $finish;
    end
  end

  // Uniform integer in [-half, half]
  function automatic int spread(int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic tick_t mk_tick(int a, int r, int lc, int rc, int tg, int ln, int y);
    tick_t t;
    t.angle  = a[IN_W-1:0];
    t.rate   = r[IN_W-1:0];
    t.lcnt   = lc[IN_W-1:0];
    t.rcnt   = rc[IN_W-1:0];
    t.target = tg[IN_W-1:0];
    t.line   = ln[LINE_W-1:0];
    t.yaw    = y[IN_W-1:0];
    return t;
  endfunction

  // Mostly plausible ticks (small tilt, encoder counts around a drifting cruise
  // speed, line near center) so the filter and integral evolve like a real
  // robot; some ticks past the fall angle; the rest full-range noise.
  function automatic tick_t rand_tick();
    int    pick;
    int    ang;
    int    mag;
    tick_t t;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      t.angle  = $urandom;
      t.rate   = $urandom;
      t.lcnt   = $urandom;
      t.rcnt   = $urandom;
      t.target = $urandom;
      t.line   = $urandom;
      t.yaw    = $urandom;
    end else begin
      cruise = cruise + spread(5);
      if (cruise > 200) cruise = 200;
      if (cruise < -200) cruise = -200;
      if (pick < 23) begin
        mag = $urandom_range(FALL_ANGLE + 1, 32767);
        ang = $urandom_range(0, 1) ? mag : -mag;
      end else begin
        ang = spread(3840);   // +-15 degrees
      end
      t = mk_tick(ang, spread(3000), cruise + spread(10), cruise + spread(10),
                  spread(512), LINE_CENTER + spread(45), spread(4000));
    end
    return t;
  endfunction

  // Offer one tick; valid stays up with a stable payload until accepted
  task automatic send_tick(input tick_t t);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    tilt_angle  <= t.angle;
    tilt_rate   <= t.rate;
    left_count  <= t.lcnt;
    right_count <= t.rcnt;
    move_target <= t.target;
    line_pos    <= t.line;
    yaw_rate    <= t.yaw;
    do @(posedge clk); while (!in_ready);
  endtask

  // Write all eight registers back to back; only called with the block idle
  task automatic program_regs(input logic [CFG_DATA_W-1:0] vals [8]);
    cfg_reg_t r;
    r = REG_BAL_KP;
    repeat (8) begin
      cfg_wen  <= 1'b1;
      cfg_idx  <= r;
      cfg_data <= vals[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_wen <= 1'b0;
  endtask

  // Receiver: random stall per beat, then ready until a beat moves
  initial begin
    int stall;
    rx_ready = 1'b0;
    forever begin
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        rx_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rx_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Back-pressure window: output side blocked while the sender keeps pushing,
  // so the output register and the tick in flight both fill and in_ready drops
  initial begin
    hold_off = 1'b0;
    @(posedge hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [CFG_DATA_W-1:0] cfg_set [8];
    int                    n_ticks;
    rst         = 1'b1;
    cfg_wen     = 1'b0;
    cfg_idx     = REG_BAL_KP;
    cfg_data    = '0;
    in_valid    = 1'b0;
    tilt_angle  = '0;
    tilt_rate   = '0;
    left_count  = '0;
    right_count = '0;
    move_target = '0;
    line_pos    = '0;
    yaw_rate    = '0;
    hold_go     = 1'b0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    cruise      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Phases: reset gains, random gains, all-max, all-min, moderate random gains
    // with back-pressure, reset gains again
    for (int ph = 0; ph < 6; ph++) begin
      cfg_set = '{BAL_KP_RST, BAL_KD_RST, SPD_KP_RST, SPD_KI_RST, STR_KP_RST,
                  STR_KD_RST, CFG_DATA_W'(BAL_PT_RST), CFG_DATA_W'(DZ_RST)};
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      case (ph)
        0: n_ticks = 110;
        1: begin
          foreach (cfg_set[i]) cfg_set[i] = $urandom;
          n_ticks = 70;
        end
        2: begin
          cfg_set = '{default: 24'h7FFFFF};
          cfg_set[REG_BAL_PT]    = 24'h007FFF;
          cfg_set[REG_DEAD_ZONE] = 24'h0003FF;
          tx_idle = 1'b0;
          n_ticks = 40;
        end
        3: begin
          cfg_set = '{default: 24'h800000};
          cfg_set[REG_BAL_PT]    = 24'h008000;
          cfg_set[REG_DEAD_ZONE] = 24'h000000;
          rx_idle = 1'b0;
          n_ticks = 40;
        end
        4: begin
          foreach (cfg_set[i]) cfg_set[i] = spread(65536);
          cfg_set[REG_BAL_PT]    = spread(2560);
          cfg_set[REG_DEAD_ZONE] = $urandom_range(0, 1023);
          tx_idle = 1'b0;
          n_ticks = 90;
        end
        default: n_ticks = 100;
      endcase
      program_regs(cfg_set);

      if (ph == 0) begin
        // zero drive: left_fwd reports not-forward, right_fwd reports forward
        send_tick(mk_tick(0, 0, 0, 0, 0, LINE_CENTER, 0));
        // fall threshold on both sides
        send_tick(mk_tick(FALL_ANGLE, 0, 0, 0, 0, LINE_CENTER, 0));
        send_tick(mk_tick(FALL_ANGLE + 1, 0, 0, 0, 0, LINE_CENTER, 0));
        send_tick(mk_tick(-FALL_ANGLE, 0, 0, 0, 0, LINE_CENTER, 0));
        send_tick(mk_tick(-FALL_ANGLE - 1, 0, 0, 0, 0, LINE_CENTER, 0));
        // wind the integral to its positive clamp, then fall clears it
        repeat (4) send_tick(mk_tick(0, 0, 32767, 32767, -32768, LINE_CENTER, 0));
        send_tick(mk_tick(-32768, 0, 32767, 32767, -32768, LINE_CENTER, 0));
        send_tick(mk_tick(0, 0, 0, 0, 0, LINE_CENTER, 0));
        // negative clamp, then fall at the positive extreme
        repeat (3) send_tick(mk_tick(0, 0, -32768, -32768, 32767, LINE_CENTER, 0));
        send_tick(mk_tick(32767, 0, -32768, -32768, 32767, LINE_CENTER, 0));
        // field extremes
        send_tick(mk_tick(32767, 32767, 32767, 32767, 32767, 255, 32767));
        send_tick(mk_tick(-32768, -32768, -32768, -32768, -32768, 0, -32768));
        send_tick(mk_tick(0, 0, 0, 0, 0, 255, 0));
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, 0, 0, LINE_CENTER, 32767));
        send_tick(mk_tick(0, 0, 0, 0, 0, LINE_CENTER, -32768));
        // small drives of each sign
        send_tick(mk_tick(100, 0, 0, 0, 0, LINE_CENTER, 0));
        send_tick(mk_tick(-100, 0, 0, 0, 0, LINE_CENTER, 0));
      end

      if (ph == 4) hold_go <= 1'b1;
      repeat (n_ticks) send_tick(rand_tick());
      in_valid <= 1'b0;

      // sender pauses here until every result of the phase is out
      do @(posedge clk); while (pending != 0);
    end

    // catch any stray beat after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("balance_robot_motor_controller_unit regression: pass");
    end else begin
      $display("balance_robot_motor_controller_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: balance_robot_motor_controller_unit.f
rtl/core/brmc_pkg.sv
rtl/core/brmc_smac.sv
rtl/core/balance_robot_motor_controller_unit.sv
test/brmc_checker.sv
test/tb.sv
